@@ rtl/core/serial_packet_deframer_crc8_defines.svh @@
// Assertion macros used by the deframer controller.
`ifndef SERIAL_PACKET_DEFRAMER_CRC8_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_CRC8_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPDC8_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPDC8_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/spdc8_pkg.sv @@
package spdc8_pkg;

   localparam int HDR_BYTES = 8;
   localparam int HDR_IDX_W = $clog2(HDR_BYTES);

   // Header byte positions
   localparam int HDR_PORT   = 0;
   localparam int HDR_FLAG   = 1;
   localparam int HDR_ID     = 2;
   localparam int HDR_SEQ    = 3;
   localparam int HDR_LEN_LO = 4;
   localparam int HDR_LEN_HI = 5;

   localparam logic [7:0]  SYNC_FIRST        = 8'h55;
   localparam logic [7:0]  SYNC_SECOND       = 8'hAA;
   localparam logic [7:0]  CRC_POLY          = 8'h07;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

   typedef enum logic [1:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HUNT    = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_CHECK   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_NONE    = 3'd0,
      STAT_OK      = 3'd1,
      STAT_XOR_ERR = 3'd2,
      STAT_CRC_ERR = 3'd3,
      STAT_LEN_ERR = 3'd4
   } status_type;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // CRC after the two sync bytes
   localparam logic [7:0] SYNC_CRC = crc8_byte(crc8_byte(8'h00, SYNC_FIRST), SYNC_SECOND);

   typedef struct packed {
      logic       load_rsp;
      logic       hdr_clear;
      logic       hdr_write;
      logic       start_payload;
      logic       pay_byte;
      logic       start_replay;
      logic       replay_step;
      kind_type   kind;
      status_type status;
      logic       show;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sync1_hit;
      logic sync2_hit;
      logic hdr_last;
      logic crc_ok;
      logic len_zero;
      logic len_over;
      logic pay_last;
      logic check_ok;
      logic replay_last;
   } dp_status_type;

endpackage

@@ rtl/core/spdc8_ctrl.sv @@
`include "serial_packet_deframer_crc8_defines.svh"

module spdc8_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  spdc8_pkg::dp_status_type dp_status,
   output logic                    replay_active,
   output spdc8_pkg::ctrl_cmd_type  cmd
);
   import spdc8_pkg::*;

   phase_type phase_ff, phase_in;
   logic      replay_ff, replay_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      step;

   // Take a byte when not replaying and the output slot frees up this cycle
   assign req_ready     = !replay_ff && (!rsp_valid_ff || rsp_ready);
   assign accept        = req_valid && req_ready;
   assign step          = accept || replay_ff;
   assign replay_active = replay_ff;
   assign rsp_valid     = rsp_valid_ff;

   // Commands for the byte being consumed
   always_comb begin
      cmd             = '0;
      cmd.kind        = KIND_HUNT;
      cmd.status      = STAT_NONE;
      cmd.load_rsp    = accept;
      cmd.replay_step = replay_ff;
      if (step) begin
         case (phase_ff)
            PH_SYNC1: begin
               cmd.kind = KIND_HUNT;
            end
            PH_SYNC2: begin
               cmd.hdr_clear = 1'b1;
            end
            PH_HEADER: begin
               cmd.kind      = KIND_HEADER;
               cmd.hdr_write = 1'b1;
               if (dp_status.hdr_last) begin
                  if (!dp_status.crc_ok) begin
                     cmd.status       = STAT_CRC_ERR;
                     cmd.start_replay = !replay_ff;
                  end else if (dp_status.len_zero) begin
                     cmd.status = STAT_OK;
                     cmd.show   = 1'b1;
                  end else if (dp_status.len_over) begin
                     cmd.status = STAT_LEN_ERR;
                     cmd.show   = 1'b1;
                  end else begin
                     cmd.start_payload = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               cmd.show = 1'b1;
               if (!dp_status.pay_last) begin
                  cmd.kind     = KIND_PAYLOAD;
                  cmd.pay_byte = 1'b1;
               end else begin
                  cmd.kind   = KIND_CHECK;
                  cmd.status = dp_status.check_ok ? STAT_OK : STAT_XOR_ERR;
               end
            end
            default: begin
               cmd.kind = KIND_HUNT;
            end
         endcase
      end
   end

   // Advance the hunt phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (dp_status.sync1_hit) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               phase_in = dp_status.sync2_hit ? PH_HEADER : PH_SYNC1;
            end
            PH_HEADER: begin
               if (dp_status.hdr_last) begin
                  phase_in = (dp_status.crc_ok && !dp_status.len_zero && !dp_status.len_over)
                             ? PH_PAYLOAD : PH_SYNC1;
               end
            end
            PH_PAYLOAD: begin
               if (dp_status.pay_last) phase_in = PH_SYNC1;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   // Replay runs for the eight stored header bytes
   always_comb begin
      replay_in = replay_ff;
      if (cmd.start_replay) begin
         replay_in = 1'b1;
      end else if (replay_ff && dp_status.replay_last) begin
         replay_in = 1'b0;
      end
   end

   // Hold the result until it is taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         replay_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         replay_ff    <= replay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SPDC8_ASSERT_IMP(a_replay_blocks_input, clock, reset, replay_ff, !req_ready,
                     "input taken during header replay")
   `SPDC8_ASSERT_NXT(a_crc_err_starts_replay, clock, reset,
                     cmd.load_rsp && cmd.status == STAT_CRC_ERR, replay_ff,
                     "header crc error did not start a replay")
   `SPDC8_ASSERT_IMP(a_replay_no_payload, clock, reset, replay_ff, phase_ff != PH_PAYLOAD,
                     "replay reached the payload phase")
   `SPDC8_ASSERT_IMP(a_replay_no_header_end, clock, reset,
                     replay_ff && phase_ff == PH_HEADER, !dp_status.hdr_last,
                     "replay completed a header")

endmodule

@@ rtl/core/spdc8_dp.sv @@
module spdc8_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   input  logic [7:0]               req_rx_byte,
   input  logic                     replay_active,
   input  spdc8_pkg::ctrl_cmd_type  cmd,
   output spdc8_pkg::dp_status_type dp_status,
   output logic [7:0]               rsp_data_byte,
   output logic [1:0]               rsp_byte_kind,
   output logic [2:0]               rsp_status,
   output logic [7:0]               rsp_port,
   output logic [7:0]               rsp_flag,
   output logic [7:0]               rsp_node_id,
   output logic [7:0]               rsp_seq_num,
   output logic [15:0]              rsp_payload_len
);
   import spdc8_pkg::*;

   logic [7:0]           hdr_store_ff [HDR_BYTES];
   logic [HDR_IDX_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [HDR_IDX_W-1:0] replay_cnt_ff, replay_cnt_in;
   logic [7:0]           crc_ff, crc_in;
   logic [15:0]          pay_left_ff, pay_left_in;
   logic [7:0]           xor_ff, xor_in;
   logic [15:0]          max_payload_ff, max_payload_in;

   logic [7:0]  data_byte_ff, data_byte_in;
   logic [1:0]  byte_kind_ff, byte_kind_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  port_ff, port_in;
   logic [7:0]  flag_ff, flag_in;
   logic [7:0]  node_id_ff, node_id_in;
   logic [7:0]  seq_num_ff, seq_num_in;
   logic [15:0] payload_len_ff, payload_len_in;

   logic [7:0]  byte_sel;
   logic [15:0] hdr_len;

   // Pick the live byte or the stored header byte under replay
   assign byte_sel = replay_active ? hdr_store_ff[replay_cnt_ff] : req_rx_byte;
   assign hdr_len  = {hdr_store_ff[HDR_LEN_HI], hdr_store_ff[HDR_LEN_LO]};

   // Status back to the controller
   always_comb begin
      dp_status.sync1_hit   = (byte_sel == SYNC_FIRST);
      dp_status.sync2_hit   = (byte_sel == SYNC_SECOND);
      dp_status.hdr_last    = (hdr_cnt_ff == HDR_IDX_W'(HDR_BYTES - 1));
      dp_status.crc_ok      = (crc_ff == byte_sel);
      dp_status.len_zero    = (hdr_len == 16'd0);
      dp_status.len_over    = (hdr_len > max_payload_ff);
      dp_status.pay_last    = (pay_left_ff == 16'd0);
      dp_status.check_ok    = (byte_sel == xor_ff);
      dp_status.replay_last = (replay_cnt_ff == HDR_IDX_W'(HDR_BYTES - 1));
   end

   // Header count, crc, payload and replay counters, check accumulator and payload limit
   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      crc_in     = crc_ff;
      if (cmd.hdr_clear) begin
         hdr_cnt_in = '0;
         crc_in     = SYNC_CRC;
      end else if (cmd.hdr_write) begin
         hdr_cnt_in = hdr_cnt_ff + HDR_IDX_W'(1);
         crc_in     = crc8_byte(crc_ff, byte_sel);
      end

      pay_left_in = pay_left_ff;
      xor_in      = xor_ff;
      if (cmd.start_payload) begin
         pay_left_in = hdr_len;
         xor_in      = 8'h00;
      end else if (cmd.pay_byte) begin
         pay_left_in = pay_left_ff - 16'd1;
         xor_in      = xor_ff ^ byte_sel;
      end

      replay_cnt_in = replay_cnt_ff;
      if (cmd.start_replay) begin
         replay_cnt_in = '0;
      end else if (cmd.replay_step) begin
         replay_cnt_in = replay_cnt_ff + HDR_IDX_W'(1);
      end

      max_payload_in = csr_wr_en ? csr_wr_data : max_payload_ff;
   end

   // Result fields, header fields zeroed unless shown
   always_comb begin
      data_byte_in   = byte_sel;
      byte_kind_in   = cmd.kind;
      status_in      = cmd.status;
      port_in        = cmd.show ? hdr_store_ff[HDR_PORT] : 8'h00;
      flag_in        = cmd.show ? hdr_store_ff[HDR_FLAG] : 8'h00;
      node_id_in     = cmd.show ? hdr_store_ff[HDR_ID] : 8'h00;
      seq_num_in     = cmd.show ? hdr_store_ff[HDR_SEQ] : 8'h00;
      payload_len_in = cmd.show ? hdr_len : 16'h0000;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff     <= '0;
         replay_cnt_ff  <= '0;
         crc_ff         <= 8'h00;
         pay_left_ff    <= 16'd0;
         xor_ff         <= 8'h00;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         hdr_cnt_ff     <= hdr_cnt_in;
         replay_cnt_ff  <= replay_cnt_in;
         crc_ff         <= crc_in;
         pay_left_ff    <= pay_left_in;
         xor_ff         <= xor_in;
         max_payload_ff <= max_payload_in;
      end
   end

   // Header store
   always_ff @(posedge clock) begin
      if (cmd.hdr_write) begin
         hdr_store_ff[hdr_cnt_ff] <= byte_sel;
      end
   end

   // Output register, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         data_byte_ff   <= data_byte_in;
         byte_kind_ff   <= byte_kind_in;
         status_ff      <= status_in;
         port_ff        <= port_in;
         flag_ff        <= flag_in;
         node_id_ff     <= node_id_in;
         seq_num_ff     <= seq_num_in;
         payload_len_ff <= payload_len_in;
      end
   end

   assign rsp_data_byte   = data_byte_ff;
   assign rsp_byte_kind   = byte_kind_ff;
   assign rsp_status      = status_ff;
   assign rsp_port        = port_ff;
   assign rsp_flag        = flag_ff;
   assign rsp_node_id     = node_id_ff;
   assign rsp_seq_num     = seq_num_ff;
   assign rsp_payload_len = payload_len_ff;

endmodule

@@ rtl/core/serial_packet_deframer_crc8.sv @@
// Sync-header packet deframer with a CRC-8 header check.
// Input channel req_*: one received byte per transfer on req_rx_byte.
// Result channel rsp_*: one result per input byte, in order: the echoed byte,
// its kind (hunt/sync, header, payload, check), a status code and the
// port, flag, id, sequence and length fields of the current header, which read
// zero outside payload, check and zero-length or oversized header-end bytes.
// csr_wr_en/csr_wr_data write the largest accepted payload length at once.
// A result is registered and valid in the cycle after its byte transfers.
// Throughput: one byte per cycle outside replays and rsp_ready stalls, set by
// the single output register, which takes a new byte in the same cycle that
// the old result is taken. After a header CRC error the eight stored header
// bytes go back through the sync hunt, one per cycle, with req_ready low.
// A stalled rsp_ready holds the result and drops req_ready until it is taken.
// Reset (synchronous): hunt for the first sync byte, no result pending,
// payload limit back to 256; header storage is not cleared.
module serial_packet_deframer_crc8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_byte_kind,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_port,
   output logic [7:0]  rsp_flag,
   output logic [7:0]  rsp_node_id,
   output logic [7:0]  rsp_seq_num,
   output logic [15:0] rsp_payload_len,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import spdc8_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   logic          replay_active;

   spdc8_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .dp_status     (dp_status),
      .replay_active (replay_active),
      .cmd           (cmd)
   );

   spdc8_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_rx_byte     (req_rx_byte),
      .replay_active   (replay_active),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_kind   (rsp_byte_kind),
      .rsp_status      (rsp_status),
      .rsp_port        (rsp_port),
      .rsp_flag        (rsp_flag),
      .rsp_node_id     (rsp_node_id),
      .rsp_seq_num     (rsp_seq_num),
      .rsp_payload_len (rsp_payload_len)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import spdc8_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BUDGET = 70;

   // One deframed result as the block should report it
   typedef struct {
      logic [7:0]  data;
      kind_type    kind;
      status_type  stat;
      logic [7:0]  port;
      logic [7:0]  flag;
      logic [7:0]  node;
      logic [7:0]  seq;
      logic [15:0] len;
   } deframed_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_byte_kind;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_port;
   logic [7:0]  rsp_flag;
   logic [7:0]  rsp_node_id;
   logic [7:0]  rsp_seq_num;
   logic [15:0] rsp_payload_len;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   serial_packet_deframer_crc8 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_kind   (rsp_byte_kind),
      .rsp_status      (rsp_status),
      .rsp_port        (rsp_port),
      .rsp_flag        (rsp_flag),
      .rsp_node_id     (rsp_node_id),
      .rsp_seq_num     (rsp_seq_num),
      .rsp_payload_len (rsp_payload_len),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Deframer state mirrored by the predictor
   phase_type   link_phase = PH_SYNC1;
   logic [7:0]  hdr_bytes [8] = '{default: 8'h00};
   logic [3:0]  hdr_fill = 4'd0;
   logic [16:0] bytes_due = 17'd0;
   logic [7:0]  xor_acc = 8'h00;
   logic [15:0] limit_now = MAX_PAYLOAD_RESET;

   logic [7:0]   rx_stream_q [$];
   deframed_type deframed_q [$];
   deframed_type want;
   int           bytes_queued = 0;
   int           bytes_taken = 0;
   int           fault_count = 0;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           ready_hold = 0;

   // CRC-8, polynomial 0x07, one data bit at a time, MSB first
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ d[i];
         r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   // Header CRC covers both sync bytes and the first seven header bytes
   function automatic logic [7:0] crc_of_header(input logic [7:0] h [8]);
      logic [7:0] c;
      c = crc8_next(crc8_next(8'h00, SYNC_FIRST), SYNC_SECOND);
      for (int i = 0; i < 7; i++) c = crc8_next(c, h[i]);
      return c;
   endfunction

   // Advance the hunt by one byte; return 1 when the header must be replayed
   function automatic bit absorb_byte(input logic [7:0] b, output kind_type k,
                                      output status_type s);
      logic [15:0] plen;
      bit          redo;
      k = KIND_HUNT;
      s = STAT_NONE;
      redo = 1'b0;
      case (link_phase)
         PH_SYNC1: begin
            if (b == SYNC_FIRST) link_phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            link_phase = (b == SYNC_SECOND) ? PH_HEADER : PH_SYNC1;
            hdr_fill = 4'd0;
         end
         PH_HEADER: begin
            k = KIND_HEADER;
            hdr_bytes[hdr_fill[2:0]] = b;
            hdr_fill = hdr_fill + 4'd1;
            if (hdr_fill == 4'd8) begin
               hdr_fill = 4'd0;
               plen = {hdr_bytes[HDR_LEN_HI], hdr_bytes[HDR_LEN_LO]};
               if (crc_of_header(hdr_bytes) != hdr_bytes[7]) begin
                  s = STAT_CRC_ERR;
                  link_phase = PH_SYNC1;
                  redo = 1'b1;
               end else if (plen == 16'd0) begin
                  s = STAT_OK;
                  link_phase = PH_SYNC1;
               end else if (plen > limit_now) begin
                  s = STAT_LEN_ERR;
                  link_phase = PH_SYNC1;
               end else begin
                  bytes_due = {1'b0, plen} + 17'd1;
                  xor_acc = 8'h00;
                  link_phase = PH_PAYLOAD;
               end
            end
         end
         default: begin
            if (bytes_due > 17'd1) begin
               k = KIND_PAYLOAD;
               xor_acc = xor_acc ^ b;
               bytes_due = bytes_due - 17'd1;
            end else begin
               k = KIND_CHECK;
               s = (b == xor_acc) ? STAT_OK : STAT_XOR_ERR;
               bytes_due = 17'd0;
               link_phase = PH_SYNC1;
            end
         end
      endcase
      return redo;
   endfunction

   // Predict the result of one transferred byte, then run any header replay
   function automatic void deframe_byte(input logic [7:0] b);
      kind_type     k, k2;
      status_type   s, s2;
      bit           redo;
      bit           show;
      logic [7:0]   saved [8];
      deframed_type r;
      redo = absorb_byte(b, k, s);
      show = (k == KIND_PAYLOAD) || (k == KIND_CHECK) ||
             (k == KIND_HEADER && (s == STAT_OK || s == STAT_LEN_ERR));
      r.data = b;
      r.kind = k;
      r.stat = s;
      r.port = show ? hdr_bytes[HDR_PORT] : 8'h00;
      r.flag = show ? hdr_bytes[HDR_FLAG] : 8'h00;
      r.node = show ? hdr_bytes[HDR_ID] : 8'h00;
      r.seq  = show ? hdr_bytes[HDR_SEQ] : 8'h00;
      r.len  = show ? {hdr_bytes[HDR_LEN_HI], hdr_bytes[HDR_LEN_LO]} : 16'h0000;
      deframed_q.push_back(r);
      if (redo) begin
         saved = hdr_bytes;
         link_phase = PH_SYNC1;
         hdr_fill = 4'd0;
         for (int i = 0; i < 8; i++) void'(absorb_byte(saved[i], k2, s2));
      end
   endfunction

   function automatic void log_fault(input string why);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $time, why);
   endfunction

   // Stimulus builders
   task automatic push_byte(input logic [7:0] b);
      rx_stream_q.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_payload(input int len, input bit bad_xor);
      logic [7:0] p, x;
      x = 8'h00;
      repeat (len) begin
         p = 8'($urandom);
         x = x ^ p;
         push_byte(p);
      end
      push_byte(bad_xor ? x ^ (8'h01 << $urandom_range(0, 7)) : x);
   endtask

   task automatic push_frame(input logic [7:0] port, input logic [7:0] flag,
                             input logic [7:0] id, input logic [7:0] seq,
                             input logic [15:0] len, input bit bad_crc, input bit bad_xor);
      logic [7:0] h [8];
      h[HDR_PORT] = port;
      h[HDR_FLAG] = flag;
      h[HDR_ID] = id;
      h[HDR_SEQ] = seq;
      h[HDR_LEN_LO] = len[7:0];
      h[HDR_LEN_HI] = len[15:8];
      h[6] = 8'($urandom);
      h[7] = crc_of_header(h);
      if (bad_crc) h[7] = h[7] ^ (8'h01 << $urandom_range(0, 7));
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      for (int i = 0; i < 8; i++) push_byte(h[i]);
      if (!bad_crc && len != 16'd0 && len <= limit_now) push_payload(len, bad_xor);
   endtask

   // Bad header whose replay finds a sync pair; two more bytes finish a good header
   task automatic push_nested(input int len_lo, input bit bad_xor);
      logic [7:0] outer [8];
      logic [7:0] inner [8];
      outer[HDR_PORT] = SYNC_FIRST;
      outer[HDR_FLAG] = SYNC_SECOND;
      for (int i = 2; i < 6; i++) outer[i] = 8'($urandom);
      outer[6] = 8'(len_lo);
      outer[7] = 8'h00;
      while (crc_of_header(outer) == outer[7]) outer[HDR_ID] = outer[HDR_ID] + 8'd1;
      for (int i = 0; i < 6; i++) inner[i] = outer[i + 2];
      inner[6] = 8'($urandom);
      inner[7] = crc_of_header(inner);
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      for (int i = 0; i < 8; i++) push_byte(outer[i]);
      push_byte(inner[6]);
      push_byte(inner[7]);
      if (len_lo != 0 && len_lo <= limit_now) push_payload(len_lo, bad_xor);
   endtask

   task automatic push_noise(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 7);
         if (r < 2) push_byte(SYNC_FIRST);
         else if (r == 2) push_byte(SYNC_SECOND);
         else push_byte(8'($urandom));
      end
      // on a random half of calls, flush any header the noise may have opened
      if ($urandom_range(0, 1) == 0) repeat (9) push_byte(8'h00);
   endtask

   task automatic random_traffic(input int budget);
      int start;
      int r;
      int cap;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         r = $urandom_range(0, 99);
         cap = (limit_now < 16) ? int'(limit_now) : 16;
         if (r < 55) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       (cap == 0 || $urandom_range(0, 9) == 0) ? 16'd0
                          : 16'($urandom_range(1, cap)), 1'b0, 1'b0);
         end else if (r < 65) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       (cap == 0) ? 16'd0 : 16'($urandom_range(1, cap)), 1'b0, 1'b1);
         end else if (r < 75) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       16'($urandom), 1'b1, 1'b0);
         end else if (r < 82 && limit_now != 16'hFFFF) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       16'($urandom_range(int'(limit_now) + 1, 65535)), 1'b0, 1'b0);
         end else if (r < 90) begin
            push_nested($urandom_range(0, (cap < 10) ? cap : 10), $urandom_range(0, 3) == 0);
         end else begin
            push_noise($urandom_range(1, 20));
         end
      end
   endtask

   // Configuration is written only while nothing is in flight
   task automatic write_limit(input logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = v;
   endtask

   // Wait until every queued byte is taken and every result checked, then let replay finish
   task automatic settle();
      while (bytes_taken != bytes_queued || deframed_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            deframe_byte(req_rx_byte);
            bytes_taken++;
         end
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_stream_q.size() != 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_stream_q.pop_front();
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: check each transfer, stall on alternating ready and stall runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               log_fault($sformatf("result %h with nothing pending", rsp_data_byte));
            end else begin
               want = deframed_q.pop_front();
               if (rsp_data_byte !== want.data || rsp_byte_kind !== want.kind ||
                   rsp_status !== want.stat || rsp_port !== want.port ||
                   rsp_flag !== want.flag || rsp_node_id !== want.node ||
                   rsp_seq_num !== want.seq || rsp_payload_len !== want.len) begin
                  log_fault($sformatf({"got byte %h kind %0d status %0d port %h flag %h ",
                     "id %h seq %h len %h; want byte %h kind %0d status %0d port %h ",
                     "flag %h id %h seq %h len %h"},
                     rsp_data_byte, rsp_byte_kind, rsp_status, rsp_port, rsp_flag,
                     rsp_node_id, rsp_seq_num, rsp_payload_len, want.data, want.kind,
                     want.stat, want.port, want.flag, want.node, want.seq, want.len));
               end
            end
         end
         if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
         end else if (rsp_ready) begin
            rsp_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12)
                                                      : $urandom_range(0, 1);
         end else begin
            rsp_ready <= 1'b1;
            ready_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 5);
         end
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      logic [15:0] limits [6];
      limits = '{16'd0, 16'd1, 16'd12, 16'($urandom_range(2, 40)), 16'hFFFF, 16'd256};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Hunt over plain bytes and broken sync pairs
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(SYNC_SECOND);
      push_byte(SYNC_FIRST);
      push_byte(8'h12);
      push_byte(SYNC_FIRST);
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      // Good, zero-length, xor error, crc error, replayed header, oversize
      push_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd3, 1'b0, 1'b0);
      push_frame(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0, 1'b0);
      push_frame(8'h01, 8'h10, 8'h02, 8'h03, 16'd2, 1'b0, 1'b1);
      push_frame(8'h11, 8'h22, 8'h33, 8'h44, 16'd5, 1'b1, 1'b0);
      push_nested(3, 1'b0);
      push_frame(8'h5A, 8'hF0, 8'h0F, 8'hA5, 16'd257, 1'b0, 1'b0);
      push_frame(8'hC3, 8'h3C, 8'h81, 8'h7E, 16'hFFFF, 1'b0, 1'b0);
      settle();

      // Length right at the limit and one past it
      write_limit(16'd4);
      push_frame(8'h21, 8'h43, 8'h65, 8'h87, 16'd4, 1'b0, 1'b0);
      push_frame(8'h21, 8'h43, 8'h65, 8'h88, 16'd5, 1'b0, 1'b0);
      settle();

      // A length beyond the reset limit passes with the widest one
      write_limit(16'hFFFF);
      push_frame(8'h9C, 8'h40, 8'h12, 8'h34, 16'd270, 1'b0, 1'b0);
      settle();

      foreach (limits[i]) begin
         write_limit(limits[i]);
         random_traffic(RANDOM_BUDGET);
         settle();
      end

      if (fault_count == 0 && deframed_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
